// File: hdl/isqrt_pkg.sv
package isqrt_pkg;

  localparam int unsigned DefInputWidth = 32;
  localparam int unsigned RootFieldW    = 16;

endpackage

// File: hdl/integer_square_root.sv
// Pipelined floor square root: one unsigned radicand of INPUT_WIDTH bits in, the low 16
// bits of floor(sqrt(radicand)) out. A chain of (INPUT_WIDTH+1)/2 cells resolves one root
// bit per cell with a single subtract and compare, and one request is taken every cycle
// unless the first cell is stalled. Each cell holds its own request while stalled, so
// empty cells keep filling while a result waits at the output.
module integer_square_root #(
  parameter int unsigned INPUT_WIDTH = isqrt_pkg::DefInputWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [INPUT_WIDTH-1:0]              radicand_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [isqrt_pkg::RootFieldW-1:0]    root_o
);

  localparam int unsigned RootW = (INPUT_WIDTH + 1) / 2;
  localparam int unsigned RadW  = 2 * RootW;

  logic [RootW:0]   stage_valid;
  logic [RootW:0]   stage_ready;
  logic [RootW:0]   stage_rem  [RootW+1];
  logic [RootW-1:0] stage_root [RootW+1];
  logic [RadW-1:0]  stage_rad  [RootW+1];

  assign stage_valid[0] = in_valid_i;
  assign in_ready_o     = stage_ready[0];
  assign stage_rem[0]   = '0;
  assign stage_root[0]  = '0;
  assign stage_rad[0]   = RadW'(radicand_i);

  for (genvar k = 0; k < RootW; k++) begin : g_cell
    isqrt_cell #(
      .ROOT_W (RootW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .rem_i   (stage_rem[k]),
      .root_i  (stage_root[k]),
      .rad_i   (stage_rad[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .rem_o   (stage_rem[k+1]),
      .root_o  (stage_root[k+1]),
      .rad_o   (stage_rad[k+1])
    );
  end

  assign stage_ready[RootW] = out_ready_i;
  assign out_valid_o        = stage_valid[RootW];
  assign root_o             = isqrt_pkg::RootFieldW'(stage_root[RootW]);

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&stage_valid[RootW:1]) && !out_ready_i)
    else $error("integer_square_root: input blocked with free cells");

endmodule

// File: hdl/isqrt_cell.sv
module isqrt_cell #(
  parameter int unsigned ROOT_W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [ROOT_W:0]     rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [ROOT_W:0]     rem_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [2*ROOT_W-1:0] rad_o
);

  localparam int unsigned RemW  = ROOT_W + 1;
  localparam int unsigned DiffW = ROOT_W + 3;
  localparam int unsigned RadW  = 2 * ROOT_W;

  logic                valid_q, valid_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [RadW-1:0]     rad_q, rad_d;
  logic [DiffW-1:0]    cand, trial, diff;
  logic                ge;
  logic                load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // bring down the next radicand digit pair and try 4*root + 1
  assign cand  = {rem_i, rad_i[RadW-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign diff  = cand - trial;
  assign ge    = cand >= trial;

  always_comb begin
    rem_d   = ge ? diff[RemW-1:0] : cand[RemW-1:0];
    root_d  = ROOT_W'({root_i, ge});
    rad_d   = rad_i << 2;
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;

  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, rem_q} <= {1'b0, root_q, 1'b0}))
    else $error("isqrt_cell: remainder out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(root_q) && $stable(rem_q))
    else $error("isqrt_cell: stalled request lost");

endmodule
